// ===== design/tmcd_pkg.sv =====
// Shared types and constants of the timeline marker crossing detector.
// No dependencies; every other design file refers to this package by scope.
package tmcd_pkg;

  localparam int SLOT_FIELD_W = 4;
  localparam int TIME_FIELD_W = 24;
  localparam int TAG_W        = 16;
  localparam int COUNT_W      = 5;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 8;
  localparam int RESULT_CAP   = 16;
  localparam int RES_CNT_W    = 5;

  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_LOAD    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_EVENTS_ENABLED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_COUNT   = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } scan_state_t;

  typedef struct packed {
    logic shift;
    logic fwd;
  } ring_ctl_t;

endpackage

// ===== design/tmcd_if.sv =====
// Channel interfaces of the timeline marker crossing detector: request items,
// result items and configuration writes. Depends on tmcd_pkg.
interface tmcd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic [tmcd_pkg::SLOT_FIELD_W-1:0]     slot_index;
  logic [tmcd_pkg::TIME_FIELD_W-1:0]     entry_time;
  logic [tmcd_pkg::TAG_W-1:0]            entry_tag;
  logic [tmcd_pkg::TIME_FIELD_W-1:0]     play_time;
  logic [tmcd_pkg::TIME_FIELD_W-1:0]     clip_length;
  logic                                  loop_mode;
  logic                                  play_forward;

  modport source (output valid, req_type, slot_index, entry_time, entry_tag, play_time,
                  clip_length, loop_mode, play_forward, input ready);
  modport sink (input valid, req_type, slot_index, entry_time, entry_tag, play_time,
                clip_length, loop_mode, play_forward, output ready);
endinterface

interface tmcd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [tmcd_pkg::SLOT_FIELD_W-1:0]     fired_slot;
  logic [tmcd_pkg::TIME_FIELD_W-1:0]     fired_time;
  logic [tmcd_pkg::TAG_W-1:0]            fired_tag;
  logic                                  last_of_run;

  modport source (output valid, fired_slot, fired_time, fired_tag, last_of_run, input ready);
  modport sink (input valid, fired_slot, fired_time, fired_tag, last_of_run, output ready);
endinterface

interface tmcd_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [tmcd_pkg::CFG_IDX_W-1:0]        index;
  logic [tmcd_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/tmcd_cell.sv =====
// One marker cell of the ring: holds a marker time and tag, takes a load,
// and shifts to either neighbor during a scan. Depends on tmcd_pkg.
module tmcd_cell #(
  parameter int TIME_BITS = 24
) (
  input  logic                       clk,
  input  tmcd_pkg::ring_ctl_t        ring_ctl,
  input  logic                       load_en,
  input  logic [TIME_BITS-1:0]       load_time,
  input  logic [tmcd_pkg::TAG_W-1:0] load_tag,
  input  logic [TIME_BITS-1:0]       next_time,
  input  logic [tmcd_pkg::TAG_W-1:0] next_tag,
  input  logic [TIME_BITS-1:0]       prev_time,
  input  logic [tmcd_pkg::TAG_W-1:0] prev_tag,
  output logic [TIME_BITS-1:0]       mk_time,
  output logic [tmcd_pkg::TAG_W-1:0] mk_tag
);

  logic [TIME_BITS-1:0]       mk_time_r;
  logic [tmcd_pkg::TAG_W-1:0] mk_tag_r;

  always_ff @(posedge clk) begin
    if (ring_ctl.shift) begin
      if (ring_ctl.fwd) begin
        mk_time_r <= next_time;
        mk_tag_r  <= next_tag;
      end else begin
        mk_time_r <= prev_time;
        mk_tag_r  <= prev_tag;
      end
    end else if (load_en) begin
      mk_time_r <= load_time;
      mk_tag_r  <= load_tag;
    end
  end

  assign mk_time = mk_time_r;
  assign mk_tag  = mk_tag_r;

endmodule

// ===== design/tmcd_scan.sv =====
// Scan controller: playhead state, window setup, head compare, pending
// result and output register. Drives the ring shift. Depends on tmcd_pkg, tmcd_if.
module tmcd_scan #(
  parameter int MAX_MARKERS = 16,
  parameter int TIME_BITS   = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tmcd_in_if.sink                      in_ch,
  tmcd_out_if.source                   out_ch,
  input  logic                         events_enabled,
  input  logic [tmcd_pkg::COUNT_W-1:0] marker_count,
  input  logic [TIME_BITS-1:0]         head_time,
  input  logic [tmcd_pkg::TAG_W-1:0]   head_tag,
  output tmcd_pkg::ring_ctl_t          ring_ctl
);

  localparam int SLOT_W = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam int CMP_W  = ((SLOT_W > tmcd_pkg::COUNT_W) ? SLOT_W : tmcd_pkg::COUNT_W) + 1;
  localparam logic [SLOT_W-1:0] LAST_K = SLOT_W'(MAX_MARKERS - 1);

  tmcd_pkg::scan_state_t state_r, state_nxt;

  logic [TIME_BITS-1:0]                  prev_r;
  logic                                  started_r;
  logic [SLOT_W-1:0]                     k_r;
  logic                                  fwd_r;
  logic [TIME_BITS-1:0]                  dep_r, arr_r, dep2_r, arr2_r;
  logic                                  neg_r, neg2_r, seg2_v_r;
  logic [tmcd_pkg::RES_CNT_W-1:0]        n_r;
  logic                                  pend_v_r;
  logic [tmcd_pkg::SLOT_FIELD_W-1:0]     pend_slot_r;
  logic [tmcd_pkg::TIME_FIELD_W-1:0]     pend_time_r;
  logic [tmcd_pkg::TAG_W-1:0]            pend_tag_r;
  logic                                  out_v_r;
  logic [tmcd_pkg::SLOT_FIELD_W-1:0]     out_slot_r;
  logic [tmcd_pkg::TIME_FIELD_W-1:0]     out_time_r;
  logic [tmcd_pkg::TAG_W-1:0]            out_tag_r;
  logic                                  out_last_r;

  logic                 adv_fire, suppress, wrap_f, wrap_b;
  logic [TIME_BITS-1:0] to_v, dur_v;
  logic [SLOT_W-1:0]    slot_now;
  logic                 hit_win, in_range, hit, out_free, step_ok, seg_end;
  logic                 push_mid, push_last, in_ready;

  assign to_v     = TIME_BITS'(in_ch.play_time);
  assign dur_v    = TIME_BITS'(in_ch.clip_length);
  assign adv_fire = in_ch.valid && in_ready && (in_ch.req_type == tmcd_pkg::REQ_ADVANCE);
  assign suppress = !events_enabled || (marker_count == '0) || (dur_v == '0);
  assign wrap_f   = in_ch.loop_mode && in_ch.play_forward && started_r && (prev_r > to_v);
  assign wrap_b   = in_ch.loop_mode && !in_ch.play_forward && (!started_r || (prev_r < to_v));

  assign slot_now = fwd_r ? k_r : (LAST_K - k_r);
  assign hit_win  = fwd_r ? ((neg_r || (head_time > dep_r)) && (head_time <= arr_r))
                          : ((head_time >= arr_r) && !neg_r && (head_time < dep_r));
  assign in_range = CMP_W'(slot_now) < CMP_W'(marker_count);
  assign hit      = (state_r == tmcd_pkg::ST_SCAN) && hit_win && in_range &&
                    (n_r < tmcd_pkg::RES_CNT_W'(tmcd_pkg::RESULT_CAP));
  assign out_free = !out_v_r || out_ch.ready;
  assign seg_end  = (k_r == LAST_K);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmcd_pkg::ST_IDLE: begin
        if (adv_fire && !suppress) state_nxt = tmcd_pkg::ST_SCAN;
      end
      tmcd_pkg::ST_SCAN: begin
        if (step_ok && seg_end && !seg2_v_r) state_nxt = tmcd_pkg::ST_FLUSH;
      end
      tmcd_pkg::ST_FLUSH: begin
        if (!pend_v_r || out_free) state_nxt = tmcd_pkg::ST_IDLE;
      end
      default: state_nxt = tmcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == tmcd_pkg::ST_IDLE);
    step_ok        = (state_r == tmcd_pkg::ST_SCAN) && !(hit && pend_v_r && !out_free);
    push_mid       = step_ok && hit && pend_v_r;
    push_last      = (state_r == tmcd_pkg::ST_FLUSH) && pend_v_r && out_free;
    ring_ctl.shift = step_ok;
    ring_ctl.fwd   = fwd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tmcd_pkg::ST_IDLE;
      prev_r    <= '0;
      started_r <= 1'b0;
      k_r       <= '0;
      seg2_v_r  <= 1'b0;
      n_r       <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv_fire) begin
        prev_r    <= to_v;
        started_r <= 1'b1;
        k_r       <= '0;
        n_r       <= '0;
        seg2_v_r  <= !suppress && (wrap_f || wrap_b);
      end
      if (step_ok) begin
        k_r <= seg_end ? '0 : (k_r + 1'b1);
        if (seg_end) seg2_v_r <= 1'b0;
        if (hit) n_r <= n_r + 1'b1;
      end
      if (step_ok && hit) begin
        pend_v_r <= 1'b1;
      end else if (push_last) begin
        pend_v_r <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_fire) begin
      fwd_r <= in_ch.play_forward;
      if (wrap_f) begin
        dep_r  <= prev_r;
        neg_r  <= 1'b0;
        arr_r  <= dur_v;
        dep2_r <= '0;
        neg2_r <= 1'b1;
        arr2_r <= to_v;
      end else if (wrap_b) begin
        dep_r  <= prev_r;
        neg_r  <= !started_r;
        arr_r  <= '0;
        dep2_r <= dur_v;
        neg2_r <= 1'b0;
        arr2_r <= to_v;
      end else begin
        dep_r  <= prev_r;
        neg_r  <= !started_r;
        arr_r  <= to_v;
        dep2_r <= prev_r;
        neg2_r <= !started_r;
        arr2_r <= to_v;
      end
    end else if (step_ok && seg_end && seg2_v_r) begin
      dep_r <= dep2_r;
      neg_r <= neg2_r;
      arr_r <= arr2_r;
    end
    if (step_ok && hit) begin
      pend_slot_r <= tmcd_pkg::SLOT_FIELD_W'(slot_now);
      pend_time_r <= tmcd_pkg::TIME_FIELD_W'(head_time);
      pend_tag_r  <= head_tag;
    end
    if (push_mid || push_last) begin
      out_slot_r <= pend_slot_r;
      out_time_r <= pend_time_r;
      out_tag_r  <= pend_tag_r;
      out_last_r <= push_last;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_v_r;
  assign out_ch.fired_slot  = out_slot_r;
  assign out_ch.fired_time  = out_time_r;
  assign out_ch.fired_tag   = out_tag_r;
  assign out_ch.last_of_run = out_last_r;

`ifndef SYNTH
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmcd_pkg::ST_IDLE) |-> !pend_v_r)
    else $error("pending result left over in idle");

  a_shift_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ring_ctl.shift |-> (state_r == tmcd_pkg::ST_SCAN))
    else $error("ring shifted outside a scan");

  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= tmcd_pkg::RES_CNT_W'(tmcd_pkg::RESULT_CAP))
    else $error("result count beyond cap");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    push_last |=> (out_ch.valid && out_ch.last_of_run))
    else $error("final item not flagged last");
`endif

endmodule

// ===== design/timeline_marker_crossing_detector_unit.sv =====
// Top level of the timeline marker crossing detector: ring of marker cells,
// scan controller and configuration registers. Depends on tmcd_pkg, tmcd_if,
// tmcd_cell and tmcd_scan.
//
// Channels: in_ch takes load items (write one marker slot) and advance items
// (move the playhead); out_ch gives one item per crossed marker, last_of_run
// set on the final one of an advance; cfg_ch writes events_enabled (index 0)
// and marker_count (index 1), always ready.
// Timing: a load item, or an advance that fires nothing by setup (events
// off, count zero, clip length zero), starts no scan. Any other advance
// rotates the marker ring once per window segment, one segment or two on a
// loop wrap, then flushes the final item. An item is held in the pending
// register until the next crossing is found or the flush, then moves to
// the output register.
// in_ch.ready is high only while no scan or flush is in progress; the last
// item may still wait in the output register when the next item is taken.
// Stall: a held output register halts the ring at the next crossing until
// out_ch.ready returns; no item is lost.
// Reset: playhead at zero and not started (a marker at tick zero fires on
// the first forward advance), events enabled, count zero; marker slots keep no
// reset value and must be loaded before use.
module timeline_marker_crossing_detector_unit #(
  parameter int MAX_MARKERS = 16,
  parameter int TIME_BITS   = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  tmcd_in_if.sink    in_ch,
  tmcd_out_if.source out_ch,
  tmcd_cfg_if.sink   cfg_ch
);

  logic                         events_enabled_r;
  logic [tmcd_pkg::COUNT_W-1:0] marker_count_r;

  tmcd_pkg::ring_ctl_t          ring_ctl;
  logic [TIME_BITS-1:0]         cell_time [MAX_MARKERS];
  logic [tmcd_pkg::TAG_W-1:0]   cell_tag  [MAX_MARKERS];
  logic [TIME_BITS-1:0]         head_time;
  logic [tmcd_pkg::TAG_W-1:0]   head_tag;
  logic                         load_fire;

  assign load_fire = in_ch.valid && in_ch.ready && (in_ch.req_type == tmcd_pkg::REQ_LOAD);

  for (genvar i = 0; i < MAX_MARKERS; i++) begin : g_cell
    tmcd_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk      (clk),
      .ring_ctl (ring_ctl),
      .load_en  (load_fire && (int'(in_ch.slot_index) == i)),
      .load_time(TIME_BITS'(in_ch.entry_time)),
      .load_tag (in_ch.entry_tag),
      .next_time(cell_time[(i + 1) % MAX_MARKERS]),
      .next_tag (cell_tag[(i + 1) % MAX_MARKERS]),
      .prev_time(cell_time[(i + MAX_MARKERS - 1) % MAX_MARKERS]),
      .prev_tag (cell_tag[(i + MAX_MARKERS - 1) % MAX_MARKERS]),
      .mk_time  (cell_time[i]),
      .mk_tag   (cell_tag[i])
    );
  end

  assign head_time = ring_ctl.fwd ? cell_time[0] : cell_time[MAX_MARKERS-1];
  assign head_tag  = ring_ctl.fwd ? cell_tag[0]  : cell_tag[MAX_MARKERS-1];

  tmcd_scan #(
    .MAX_MARKERS(MAX_MARKERS),
    .TIME_BITS  (TIME_BITS)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .events_enabled(events_enabled_r),
    .marker_count  (marker_count_r),
    .head_time     (head_time),
    .head_tag      (head_tag),
    .ring_ctl      (ring_ctl)
  );

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      events_enabled_r <= 1'b1;
      marker_count_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        tmcd_pkg::REG_EVENTS_ENABLED: events_enabled_r <= cfg_ch.data[0];
        tmcd_pkg::REG_MARKER_COUNT:   marker_count_r   <= cfg_ch.data[tmcd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
